/* sv/u8cc_pkg.sv */
// ----------------------------------------------------------------------------
// u8cc_pkg: shared types and tables for the UTF-8 case converter
// Holds the two-byte letter pair table, the ASCII conversion helper and the
// queue entry type passed from the classifier to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package u8cc_pkg;

  localparam int PAIR_COUNT = 19;

  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] LEAD_C5    = 8'hC5;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  // direction codes
  localparam logic DIR_UPPER = 1'b0;
  localparam logic DIR_LOWER = 1'b1;

  // columns: lower lead, lower trail, upper lead, upper trail
  localparam logic [7:0] PAIR_TABLE [PAIR_COUNT][4] = '{
    '{8'hC3, 8'hA9, 8'hC3, 8'h89}, '{8'hC3, 8'hA8, 8'hC3, 8'h88},
    '{8'hC3, 8'hA0, 8'hC3, 8'h80}, '{8'hC3, 8'hB9, 8'hC3, 8'h99},
    '{8'hC3, 8'hA2, 8'hC3, 8'h82}, '{8'hC3, 8'hAA, 8'hC3, 8'h8A},
    '{8'hC3, 8'hAE, 8'hC3, 8'h8E}, '{8'hC3, 8'hB4, 8'hC3, 8'h94},
    '{8'hC3, 8'hBB, 8'hC3, 8'h9B}, '{8'hC3, 8'hAB, 8'hC3, 8'h8B},
    '{8'hC3, 8'hAF, 8'hC3, 8'h8F}, '{8'hC3, 8'hBC, 8'hC3, 8'h9C},
    '{8'hC3, 8'hBF, 8'hC5, 8'hB8}, '{8'hC3, 8'hA7, 8'hC3, 8'h87},
    '{8'hC5, 8'h93, 8'hC5, 8'h92}, '{8'hC3, 8'hA6, 8'hC3, 8'h86},
    '{8'hC3, 8'hA5, 8'hC3, 8'h85}, '{8'hC3, 8'hA4, 8'hC3, 8'h84},
    '{8'hC3, 8'hB6, 8'hC3, 8'h96}
  };

  // one queued job: one or two output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       eos;
  } u8cc_entry_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] lead;
    logic [7:0] trail;
  } pair_hit_t;

  // ASCII letter shift in the selected direction
  function automatic logic [7:0] convert_ascii(input logic [7:0] b, input logic dir);
    logic [7:0] res;
    res = b;
    if (dir == DIR_UPPER) begin
      if (b inside {[8'h61:8'h7A]}) res = b - CASE_SHIFT;
    end else begin
      if (b inside {[8'h41:8'h5A]}) res = b + CASE_SHIFT;
    end
    return res;
  endfunction

  // parallel match of a lead/trail pair against the source columns
  function automatic pair_hit_t pair_lookup(input logic [7:0] lead, input logic [7:0] trail,
                                            input logic dir);
    pair_hit_t res;
    logic [7:0] src_lead;
    logic [7:0] src_trail;
    res = '0;
    for (int i = 0; i < PAIR_COUNT; i++) begin
      src_lead  = (dir == DIR_LOWER) ? PAIR_TABLE[i][2] : PAIR_TABLE[i][0];
      src_trail = (dir == DIR_LOWER) ? PAIR_TABLE[i][3] : PAIR_TABLE[i][1];
      if (src_lead == lead && src_trail == trail) begin
        res.hit   = 1'b1;
        res.lead  = (dir == DIR_LOWER) ? PAIR_TABLE[i][0] : PAIR_TABLE[i][2];
        res.trail = (dir == DIR_LOWER) ? PAIR_TABLE[i][1] : PAIR_TABLE[i][3];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/u8cc_front.sv */
// ----------------------------------------------------------------------------
// u8cc_front: input classifier
// Accepts one byte per item, holds a pending lead byte and turns each item
// into a queue entry of zero, one or two output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cc_front
  import u8cc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        direction,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_string,
  input  wire logic        q_full,
  output logic             q_push,
  output u8cc_entry_t      q_entry
);

  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_lead_r,  held_lead_nxt;
  logic       accept;
  logic       is_lead;
  logic [7:0] conv_byte;
  pair_hit_t  hit;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_lead   = (in_data_byte == LEAD_C3 || in_data_byte == LEAD_C5) &&
                     !in_end_of_string;
  assign conv_byte = convert_ascii(in_data_byte, direction);
  assign hit       = pair_lookup(held_lead_r, in_data_byte, direction);

  // classify the item
  always_comb begin
    q_entry        = '0;
    q_entry.eos    = in_end_of_string;
    q_push         = 1'b0;
    held_valid_nxt = held_valid_r;
    held_lead_nxt  = held_lead_r;
    if (accept) begin
      held_valid_nxt = 1'b0;
      held_lead_nxt  = '0;
      if (held_valid_r) begin
        q_push = 1'b1;
        if (hit.hit) begin
          q_entry.two   = 1'b1;
          q_entry.byte0 = hit.lead;
          q_entry.byte1 = hit.trail;
        end else begin
          q_entry.byte0 = held_lead_r;
          if (is_lead) begin
            held_valid_nxt = 1'b1;
            held_lead_nxt  = in_data_byte;
          end else begin
            q_entry.two   = 1'b1;
            q_entry.byte1 = conv_byte;
          end
        end
      end else if (is_lead) begin
        held_valid_nxt = 1'b1;
        held_lead_nxt  = in_data_byte;
      end else begin
        q_push        = 1'b1;
        q_entry.byte0 = conv_byte;
      end
    end
  end

  // held lead state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_lead_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_lead_r  <= held_lead_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/u8cc_queue.sv */
// ----------------------------------------------------------------------------
// u8cc_queue: entry queue between classifier and emitter
// Small circular FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cc_queue
  import u8cc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire u8cc_entry_t push_entry,
  input  wire logic        pop,
  output u8cc_entry_t      head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8cc_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

/* sv/u8cc_back.sv */
// ----------------------------------------------------------------------------
// u8cc_back: byte emitter
// Drains queue entries one output byte per cycle, while out_stall is low, into a
// registered output stage and marks the run and string ends.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cc_back
  import u8cc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire u8cc_entry_t head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_run_last,
  output logic             out_string_last
);

  logic       valid_r, valid_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       run_last_r, run_last_nxt;
  logic       str_last_r, str_last_nxt;
  logic       load;

  assign load = !valid_r || !out_stall;

  // select the next byte from the head entry
  always_comb begin
    valid_nxt    = valid_r;
    phase_nxt    = phase_r;
    byte_nxt     = byte_r;
    run_last_nxt = run_last_r;
    str_last_nxt = str_last_r;
    q_pop        = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        if (phase_r) begin
          byte_nxt     = head.byte1;
          run_last_nxt = 1'b1;
          str_last_nxt = head.eos;
          phase_nxt    = 1'b0;
          q_pop        = 1'b1;
        end else begin
          byte_nxt     = head.byte0;
          run_last_nxt = !head.two;
          str_last_nxt = head.eos && !head.two;
          phase_nxt    = head.two;
          q_pop        = !head.two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    run_last_r <= run_last_nxt;
    str_last_r <= str_last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_out_byte    = byte_r;
  assign out_run_last    = run_last_r;
  assign out_string_last = str_last_r;

endmodule

`default_nettype wire

/* sv/utf8_case_converter_unit.sv */
// Path: a result byte passes the queue storage and then the emitter output register after
//   the item that causes it is accepted; a C3/C5 lead waits for the next item.
// Throughput: one item per cycle in while the queue is not full, one byte per cycle out
//   through the emitter register while out_stall is low; two-byte items hold it for both bytes.
// Reset: synchronous active-low rst_n clears the held lead, the queue, the output
//   valid and sets direction to upper case.
// ----------------------------------------------------------------------------
// utf8_case_converter_unit: streaming UTF-8 case converter
// Classifier front end, entry queue and byte emitter, plus the direction
// register on its own write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_case_converter_unit
  import u8cc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_string,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_run_last,
  output logic             out_string_last
);

  logic        direction_r;
  logic        q_push, q_pop, q_full, q_empty;
  u8cc_entry_t q_in, q_head;

  // direction register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_UPPER;
    end else if (cfg_valid && cfg_ready) begin
      direction_r <= cfg_data;
    end
  end

  u8cc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .direction        (direction_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in)
  );

  u8cc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  u8cc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

endmodule

`default_nettype wire

/* tb/utf8_case_converter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_case_converter_checker: scoreboard for the UTF-8 case converter
// Watches the config, input and result channels, predicts the converted
// bytes of every accepted item and compares them in order with the results.
// ----------------------------------------------------------------------------

module utf8_case_converter_checker
  import u8cc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_out_byte,
  input  logic       out_run_last,
  input  logic       out_string_last,
  output int         fail_count,
  output int         pending_count,
  output int         checked_count,
  output int         swap_count
);

  localparam int LETTER_COUNT = 19;
  localparam int REPORT_LIMIT = 10;

  // lower lead, lower trail, upper lead, upper trail
  localparam logic [7:0] LETTER_MAP [LETTER_COUNT][4] = '{
    '{8'hC3, 8'hA9, 8'hC3, 8'h89}, '{8'hC3, 8'hA8, 8'hC3, 8'h88},
    '{8'hC3, 8'hA0, 8'hC3, 8'h80}, '{8'hC3, 8'hB9, 8'hC3, 8'h99},
    '{8'hC3, 8'hA2, 8'hC3, 8'h82}, '{8'hC3, 8'hAA, 8'hC3, 8'h8A},
    '{8'hC3, 8'hAE, 8'hC3, 8'h8E}, '{8'hC3, 8'hB4, 8'hC3, 8'h94},
    '{8'hC3, 8'hBB, 8'hC3, 8'h9B}, '{8'hC3, 8'hAB, 8'hC3, 8'h8B},
    '{8'hC3, 8'hAF, 8'hC3, 8'h8F}, '{8'hC3, 8'hBC, 8'hC3, 8'h9C},
    '{8'hC3, 8'hBF, 8'hC5, 8'hB8}, '{8'hC3, 8'hA7, 8'hC3, 8'h87},
    '{8'hC5, 8'h93, 8'hC5, 8'h92}, '{8'hC3, 8'hA6, 8'hC3, 8'h86},
    '{8'hC3, 8'hA5, 8'hC3, 8'h85}, '{8'hC3, 8'hA4, 8'hC3, 8'h84},
    '{8'hC3, 8'hB6, 8'hC3, 8'h96}
  };

  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_last;
    logic       string_last;
  } converted_byte_t;

  converted_byte_t expected_bytes [$];
  logic            dir_q;
  logic            held_valid;
  logic [7:0]      held_lead;

  // row of the letter whose source form is lead/trail, -1 if none
  function automatic int match_letter(input logic [7:0] lead, input logic [7:0] trail);
    int col;
    col = (dir_q == DIR_LOWER) ? 2 : 0;
    for (int i = 0; i < LETTER_COUNT; i++)
      if (LETTER_MAP[i][col] == lead && LETTER_MAP[i][col + 1] == trail) return i;
    return -1;
  endfunction

  function automatic logic [7:0] shift_letter(input logic [7:0] b);
    if (dir_q == DIR_UPPER && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    if (dir_q == DIR_LOWER && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  // work out the bytes one input item produces and queue them
  function automatic void convert_item(input logic [7:0] b, input logic eos);
    logic [7:0]      emitted [$];
    converted_byte_t entry;
    int              row;
    int              dst;
    logic            paired;
    paired = 1'b0;
    dst = (dir_q == DIR_LOWER) ? 0 : 2;
    if (held_valid) begin
      row = match_letter(held_lead, b);
      held_valid = 1'b0;
      if (row >= 0) begin
        emitted.push_back(LETTER_MAP[row][dst]);
        emitted.push_back(LETTER_MAP[row][dst + 1]);
        paired = 1'b1;
        swap_count++;
      end else begin
        emitted.push_back(held_lead);
      end
      held_lead = '0;
    end
    if (!paired) begin
      if ((b == LEAD_C3 || b == LEAD_C5) && !eos) begin
        held_valid = 1'b1;
        held_lead  = b;
      end else begin
        emitted.push_back(shift_letter(b));
      end
    end
    foreach (emitted[i]) begin
      entry.byte_val    = emitted[i];
      entry.run_last    = (i == emitted.size() - 1);
      entry.string_last = entry.run_last && eos;
      expected_bytes.push_back(entry);
    end
  endfunction

  initial begin
    fail_count    = 0;
    checked_count = 0;
    swap_count    = 0;
  end

  always @(posedge clk) begin
    converted_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      dir_q      = DIR_UPPER;
      held_valid = 1'b0;
      held_lead  = '0;
    end else begin
      // results first: they belong to items accepted on earlier edges
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: byte %02h run_last %b string_last %b",
                     $time, out_out_byte, out_run_last, out_string_last);
        end else begin
          want = expected_bytes.pop_front();
          checked_count++;
          if (out_out_byte !== want.byte_val || out_run_last !== want.run_last ||
              out_string_last !== want.string_last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch: byte exp %02h got %02h, run_last exp %b got %b, %s %b got %b",
                       $time, want.byte_val, out_out_byte, want.run_last, out_run_last,
                       "string_last exp", want.string_last, out_string_last);
          end
        end
      end
      // an item on the same edge as a write still sees the old direction
      if (in_valid && !in_stall) convert_item(in_data_byte, in_end_of_string);
      if (cfg_valid && cfg_ready) dir_q = cfg_data;
    end
    pending_count <= expected_bytes.size();
  end

endmodule

/* tb/tb_utf8_case_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_case_converter_unit: testbench top for the UTF-8 case converter
// Drives directed edge cases and random UTF-8 strings in both directions,
// with random idling on both sides and one long output hold-off; the
// checker beside the block scores every result byte.
// ----------------------------------------------------------------------------

module tb_utf8_case_converter_unit;
  import u8cc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int LIMIT_CYCLES  = 200000;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       cfg_valid        = 1'b0;
  logic       cfg_data         = 1'b0;
  logic       in_valid         = 1'b0;
  logic [7:0] in_data_byte     = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_stall        = 1'b0;
  logic       cfg_ready;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_out_byte;
  logic       out_run_last;
  logic       out_string_last;

  int fail_count;
  int pending_count;
  int checked_count;
  int swap_count;
  int cycle_count = 0;
  int items_sent  = 0;

  // idling controls and long hold-off handshake
  bit sender_idles    = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_phase      = 1'b0;
  bit hold_done       = 1'b0;

  logic [7:0] text_bytes [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  utf8_case_converter_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

  utf8_case_converter_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count),
    .swap_count      (swap_count)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_receiver
    int burst;
    forever begin
      @(posedge clk);
      if (hold_phase && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item, holding it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // send the queued string, end flag on its last byte
  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= dir;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random string: mostly letters and listed two-byte letters, some noise
  function automatic void build_string(input int max_symbols);
    int         symbols;
    int         pick;
    int         row;
    int         col;
    logic [7:0] lead;
    text_bytes.delete();
    symbols = $urandom_range(1, max_symbols);
    repeat (symbols) begin
      pick = $urandom_range(0, 99);
      lead = $urandom_range(0, 1) ? LEAD_C5 : LEAD_C3;
      if (pick < 40) begin
        text_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                                  : 8'($urandom_range(8'h61, 8'h7A)));
      end else if (pick < 70) begin
        row = $urandom_range(0, PAIR_COUNT - 1);
        col = $urandom_range(0, 1) * 2;
        text_bytes.push_back(PAIR_TABLE[row][col]);
        text_bytes.push_back(PAIR_TABLE[row][col + 1]);
      end else if (pick < 80) begin
        // lead followed by an arbitrary byte
        text_bytes.push_back(lead);
        text_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 95) begin
        text_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_bytes.push_back(lead);
      end
    end
  endfunction

  initial begin : stimulus
    int start_count;
    bit paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ASCII bounds, non-letters, extremes and a zero byte
    write_direction(DIR_UPPER);
    text_bytes = '{8'h61, 8'h7A, 8'h41, 8'h5A, 8'h40, 8'h60, 8'h7B, 8'h01, 8'hFF, 8'h00};
    send_text();
    // letter swaps incl. the lead change, a lead followed by a lead
    text_bytes = '{8'hC3, 8'hA9, 8'hC3, 8'hBF, 8'hC5, 8'h93, 8'hC3, 8'hC3, 8'h41};
    send_text();
    // lead carrying the end flag passes through
    send_byte(LEAD_C5, 1'b1);
    // direction flipped while a lead is held
    send_byte(LEAD_C3, 1'b0);
    write_direction(DIR_LOWER);
    send_byte(8'h89, 1'b1);
    // lower direction: lead change back, oe, ASCII, source form not matching
    text_bytes = '{8'hC5, 8'hB8, 8'hC5, 8'h92, 8'h41, 8'h7A, 8'hC3, 8'hA9};
    send_text();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == PHASE_COUNT - 1) begin
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end
      if (phase == 0) write_direction(DIR_UPPER);
      else if (phase == 1) write_direction(DIR_LOWER);
      else write_direction($urandom_range(0, 1) ? DIR_LOWER : DIR_UPPER);

      // long output hold-off while the sender keeps pushing
      if (phase == 2) begin
        hold_phase = 1'b1;
        start_count = items_sent;
        while (items_sent - start_count < 30) begin
          build_string(6);
          send_text();
        end
        in_valid <= 1'b0;
        while (!hold_done) @(posedge clk);
        hold_phase = 1'b0;
      end

      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        build_string(12);
        send_text();
        if (phase == 4 && !paused && items_sent - start_count >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    $display("Run covered %0d input bytes in both directions, directed edge cases included,",
             items_sent);
    $display("with a long output hold-off; %0d result bytes checked, %0d letter swaps.",
             checked_count, swap_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
